// File: rtl/tss_pkg.sv
// Shared types and constants for the delay-aware task slot scheduler.
// No dependencies; imported by every module of the block.
package tss_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int TICK_BITS  = 32;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

    // Field widths fixed by the stream format
    localparam int OP_W    = 3;
    localparam int DTICK_W = 32;
    localparam int TSLOT_W = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_DELAY  = 3'd1;
    localparam logic [OP_W-1:0] OP_YIELD  = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
    localparam logic [OP_W-1:0] OP_EXIT   = 3'd5;

    typedef logic [TICK_BITS-1:0] t_tick;
    typedef logic [SLOT_BITS-1:0] t_slot_idx;

    typedef struct packed {
        t_tick stamp;
        t_tick wait_cnt;
    } t_slot_entry;

    typedef struct packed {
        logic        we;
        t_slot_idx   addr;
        t_slot_entry data;
    } t_ram_wr;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [DTICK_W-1:0] delay_ticks;
        logic [TSLOT_W-1:0] task_slot;
    } t_cmd;

    typedef struct packed {
        logic       add_ok;
        logic [2:0] new_slot;
        logic [2:0] running_task;
    } t_result;

endpackage

// File: rtl/tss_slot_ram.sv
// Slot table memory: stamp and wait count per task slot.
// One write port, one read port, registered read data. Uses tss_pkg.
module tss_slot_ram
    import tss_pkg::*;
(
    input  logic        i_clk,
    input  t_ram_wr     i_wr,
    input  logic        i_re,
    input  t_slot_idx   i_raddr,
    output t_slot_entry o_rdata
);

    t_slot_entry r_mem [SLOT_COUNT];
    t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tss_ctrl.sv
// Operation sequencer: tick counter, in-use flags, current task and the
// slot scan that reads the slot table one entry a cycle. Uses tss_pkg.
module tss_ctrl
    import tss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sched_en,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_result     o_res,
    output t_ram_wr     o_ram_wr,
    output logic        o_ram_re,
    output t_slot_idx   o_ram_raddr,
    input  t_slot_entry i_ram_rdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam t_slot_idx LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

    logic [1:0]            r_state, n_state;
    t_tick                 r_tick, n_tick;
    logic [SLOT_COUNT-1:0] r_in_use, n_in_use;
    t_slot_idx             r_cur, n_cur;
    t_slot_idx             r_new, n_new;
    logic                  r_ok, n_ok;
    t_slot_idx             r_idx, n_idx;
    logic                  r_iss_done, n_iss_done;
    logic                  r_chk_vld, n_chk_vld;
    t_slot_idx             r_chk_idx, n_chk_idx;
    t_cmd                  r_cmd, n_cmd;

    t_tick     end_tick;
    logic      elapsed;
    logic      free_found;
    t_slot_idx free_idx;
    logic      do_switch;

    // delay over: stamp ahead of the counter, or stamp + wait behind it
    always_comb begin
        end_tick = i_ram_rdata.stamp + i_ram_rdata.wait_cnt;
        elapsed  = (i_ram_rdata.stamp > r_tick) || (end_tick < r_tick);
    end

    // lowest free slot from 1 up
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 1; i--) begin
            if (!r_in_use[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_BITS'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_in_use   = r_in_use;
        n_cur      = r_cur;
        n_new      = r_new;
        n_ok       = r_ok;
        n_idx      = r_idx;
        n_iss_done = r_iss_done;
        n_chk_vld  = r_chk_vld;
        n_chk_idx  = r_chk_idx;
        n_cmd      = r_cmd;
        o_cmd_ready   = 1'b0;
        o_res_valid   = 1'b0;
        o_ram_wr.we   = 1'b0;
        o_ram_wr.addr = r_cur;
        o_ram_wr.data = '0;
        o_ram_re      = 1'b0;
        o_ram_raddr   = r_idx;
        do_switch     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_new   = '0;
                    n_ok    = 1'b0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_cmd.operation) inside
                    OP_TICK: begin
                        if (i_sched_en) begin
                            n_tick    = r_tick + t_tick'(1);
                            do_switch = 1'b1;
                        end
                    end
                    OP_DELAY, OP_YIELD: begin
                        o_ram_wr.we         = 1'b1;
                        o_ram_wr.data.stamp = r_tick;
                        o_ram_wr.data.wait_cnt = (r_cmd.operation == OP_DELAY) ?
                            t_tick'(r_cmd.delay_ticks) : t_tick'(1);
                        do_switch = 1'b1;
                    end
                    OP_ADD: begin
                        if (free_found) begin
                            n_in_use[free_idx] = 1'b1;
                            o_ram_wr.we   = 1'b1;
                            o_ram_wr.addr = free_idx;
                            n_new = free_idx;
                            n_ok  = 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if ((r_cmd.task_slot != '0) &&
                            (32'(r_cmd.task_slot) < SLOT_COUNT)) begin
                            n_in_use[SLOT_BITS'(r_cmd.task_slot)] = 1'b0;
                        end
                        do_switch = 1'b1;
                    end
                    OP_EXIT: begin
                        if (r_cur != '0) begin
                            n_in_use[r_cur] = 1'b0;
                        end
                        do_switch = 1'b1;
                    end
                    default: begin
                    end
                endcase

                if (!do_switch) begin
                    n_state = ST_DONE;
                end else if (r_cur != '0) begin
                    n_cur   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_idx      = SLOT_BITS'(1);
                    n_iss_done = 1'b0;
                    n_chk_vld  = 1'b0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue read for r_idx, check the entry read last cycle
                o_ram_re  = !r_iss_done;
                n_chk_vld = !r_iss_done;
                n_chk_idx = r_idx;
                if (!r_iss_done) begin
                    if (r_idx == LAST_SLOT) begin
                        n_iss_done = 1'b1;
                    end else begin
                        n_idx = r_idx + t_slot_idx'(1);
                    end
                end
                if (r_chk_vld && r_in_use[r_chk_idx] && elapsed) begin
                    n_cur   = r_chk_idx;
                    n_state = ST_DONE;
                end else if (r_chk_vld && (r_chk_idx == LAST_SLOT)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tick     <= '0;
            r_in_use   <= SLOT_COUNT'(1);
            r_cur      <= '0;
            r_new      <= '0;
            r_ok       <= 1'b0;
            r_idx      <= '0;
            r_iss_done <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_chk_idx  <= '0;
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_in_use   <= n_in_use;
            r_cur      <= n_cur;
            r_new      <= n_new;
            r_ok       <= n_ok;
            r_idx      <= n_idx;
            r_iss_done <= n_iss_done;
            r_chk_vld  <= n_chk_vld;
            r_chk_idx  <= n_chk_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_res.running_task = 3'(r_cur);
    assign o_res.new_slot     = 3'(r_new);
    assign o_res.add_ok       = r_ok;

endmodule

// File: rtl/delay_aware_task_slot_scheduler_top.sv
// Each beat passes the sequencer states idle, exec and done, then the output
// register; a switch from idle also passes the scan state, which reads the
// slot table one entry a cycle through the single read port of the slot memory.
// The sequencer runs one operation at a time; the output register holds one more.
// Reset (i_rst_n, synchronous, active low): tick counter 0, only slot 0 in
// use, idle task current, scheduler disabled, output register empty.
//
// Top level of the task slot scheduler. Depends on tss_pkg, tss_slot_ram
// and tss_ctrl.
module delay_aware_task_slot_scheduler_top
    import tss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // scheduler enable register
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // operation beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [31:0] delay_ticks, [34:32] task_slot, rest 0
    input  logic [2:0]  s_axis_tuser,  // [2:0] operation
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [2:0] running_task, [5:3] new_slot, [6] add_ok
);

    logic        r_sched_en;
    logic        r_out_vld;
    t_result     r_out;

    t_cmd        cmd;
    logic        res_valid;
    logic        res_ready;
    t_result     res;
    t_ram_wr     ram_wr;
    logic        ram_re;
    t_slot_idx   ram_raddr;
    t_slot_entry ram_rdata;

    // enable gates tick operations only; it is to be written while the block is idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_sched_en <= i_cfg_wdata;
        end
    end

    assign cmd.operation   = s_axis_tuser;
    assign cmd.delay_ticks = s_axis_tdata[31:0];
    assign cmd.task_slot   = s_axis_tdata[34:32];

    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sched_en  (r_sched_en),
        .i_cmd_valid (s_axis_tvalid),
        .o_cmd_ready (s_axis_tready),
        .i_cmd       (cmd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_wr    (ram_wr),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // stamp / wait table
    tss_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register: the sequencer hands off a result and takes the next
    // beat while this one waits for the sink
    assign res_ready = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out.add_ok, r_out.new_slot, r_out.running_task};

endmodule

// File: dv/delay_aware_task_slot_scheduler_top_tb.sv
// Self-checking testbench for delay_aware_task_slot_scheduler_top: directed and random
// scheduler operations, with every result beat checked against a predictor held here.
// Depends on tss_pkg and the scheduler RTL.
module delay_aware_task_slot_scheduler_top_tb;
    import tss_pkg::*;

    // codes outside the defined set; the block must echo the running task
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam int HOLD_CYCLES = 300;  // long receiver hold-off
    localparam int STALL_LIMIT = 3000; // cycles with no beat on either side
    localparam int MAX_SHOWN   = 10;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // [31:0] delay_ticks, [34:32] task_slot, rest 0
    logic [2:0]  s_axis_tuser  = '0;   // [2:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [2:0] running_task, [5:3] new_slot, [6] add_ok

    delay_aware_task_slot_scheduler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Scheduler predictor state
    // ---------------------------------------------------------------
    t_tick     sched_tick;
    logic      slot_busy     [SLOT_COUNT];
    t_tick     slot_since    [SLOT_COUNT];
    t_tick     slot_wait_len [SLOT_COUNT];
    t_slot_idx active_slot;
    logic      sched_on;

    t_result   pending_results [$];
    int        bad_beats;

    int        tx_idle_pct  = 0;
    int        rx_stall_pct = 0;
    bit        hold_request = 1'b0;

    task automatic reset_model();
        sched_tick  = '0;
        active_slot = '0;
        sched_on    = 1'b0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_busy[s]     = (s == 0);
            slot_since[s]    = '0;
            slot_wait_len[s] = '0;
        end
        bad_beats = 0;
    endtask

    // delay is over once the stamp lies ahead of the tick count or stamp+wait
    // (wrapped) lies behind it
    function automatic bit slot_ready(int s);
        t_tick wake_at;
        wake_at = slot_since[s] + slot_wait_len[s];
        return (slot_since[s] > sched_tick) || (wake_at < sched_tick);
    endfunction

    // idle hands over to the lowest ready slot; any other task goes back to idle
    function automatic t_slot_idx next_to_run();
        t_slot_idx nxt;
        nxt = '0;
        if (active_slot == 0) begin
            for (int s = SLOT_COUNT - 1; s >= 1; s--) begin
                if (slot_busy[s] && slot_ready(s)) nxt = t_slot_idx'(s);
            end
        end
        return nxt;
    endfunction

    function automatic t_result schedule_op(input logic [OP_W-1:0] op,
                                            input logic [DTICK_W-1:0] dt,
                                            input logic [TSLOT_W-1:0] ts);
        t_result r;
        bit      found;
        r     = '0;
        found = 1'b0;
        case (op)
            OP_TICK: begin
                if (sched_on) begin
                    sched_tick  = sched_tick + 1'b1;
                    active_slot = next_to_run();
                end
            end
            OP_DELAY, OP_YIELD: begin
                slot_wait_len[active_slot] = (op == OP_DELAY) ? dt : t_tick'(1);
                slot_since[active_slot]    = sched_tick;
                active_slot                = next_to_run();
            end
            OP_ADD: begin
                for (int s = 1; s < SLOT_COUNT; s++) begin
                    if (!found && !slot_busy[s]) begin
                        found            = 1'b1;
                        slot_busy[s]     = 1'b1;
                        slot_since[s]    = '0;
                        slot_wait_len[s] = '0;
                        r.new_slot       = 3'(s);
                        r.add_ok         = 1'b1;
                    end
                end
            end
            OP_DELETE: begin
                if (ts != 0 && ts < SLOT_COUNT) slot_busy[ts] = 1'b0;
                active_slot = next_to_run();
            end
            OP_EXIT: begin
                if (active_slot != 0) slot_busy[active_slot] = 1'b0;
                active_slot = next_to_run();
            end
            default: ;
        endcase
        r.running_task = 3'(active_slot);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input side: every accepted beat yields one expected result
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pending_results.push_back(schedule_op(s_axis_tuser, s_axis_tdata[31:0],
                                                  s_axis_tdata[34:32]));
    end

    // ---------------------------------------------------------------
    // Output side: compare against the oldest expectation
    // ---------------------------------------------------------------
    t_result seen_result;
    t_result want_result;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_result = t_result'(m_axis_tdata[6:0]);
            if (pending_results.size() == 0) begin
                bad_beats++;
                if (bad_beats <= MAX_SHOWN)
                    $display("ERROR: result beat with none expected: run=%0d new=%0d ok=%0d",
                             seen_result.running_task, seen_result.new_slot,
                             seen_result.add_ok);
            end else begin
                want_result = pending_results.pop_front();
                if (seen_result.running_task !== want_result.running_task ||
                    seen_result.new_slot !== want_result.new_slot ||
                    seen_result.add_ok !== want_result.add_ok) begin
                    bad_beats++;
                    if (bad_beats <= MAX_SHOWN)
                        $display("ERROR: exp run=%0d new=%0d ok=%0d, got run=%0d new=%0d ok=%0d",
                                 want_result.running_task, want_result.new_slot,
                                 want_result.add_ok, seen_result.running_task,
                                 seen_result.new_slot, seen_result.add_ok);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : rx_ready_gen
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: nothing moving on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // valid stays high between back-to-back beats; it only drops on a gap
    task automatic send_op(input logic [OP_W-1:0] op, input logic [DTICK_W-1:0] dt,
                           input logic [TSLOT_W-1:0] ts);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, ts, dt};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // sender pauses until every expected result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_sched_enable(input logic value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sched_on     = value;
    endtask

    // Mostly well-formed traffic: ticks, short delays, yields, adds and removals,
    // with wide delays, slot 0 deletes and undefined codes as noise.
    task automatic send_random_op();
        int               pick;
        logic [OP_W-1:0]    op;
        logic [DTICK_W-1:0] dt;
        logic [TSLOT_W-1:0] ts;
        pick = $urandom_range(99);
        dt   = $urandom();
        ts   = 3'($urandom_range(7));
        if (pick < 30) begin
            op = OP_TICK;
        end else if (pick < 44) begin
            op = OP_DELAY;
            case ($urandom_range(5))
                0: ;
                1: dt = 32'hFFFF_FFFF - $urandom_range(8);
                default: dt = $urandom_range(8);
            endcase
        end else if (pick < 56) begin
            op = OP_YIELD;
        end else if (pick < 71) begin
            op = OP_ADD;
        end else if (pick < 82) begin
            op = OP_DELETE;
            if ($urandom_range(9) != 0) ts = 3'($urandom_range(7, 1));
        end else if (pick < 96) begin
            op = OP_EXIT;
        end else begin
            op = $urandom_range(1) ? OP_RSVD_6 : OP_RSVD_7;
        end
        send_op(op, dt, ts);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_cases();
        set_idling(0, 0);
        write_sched_enable(1'b0);
        send_op(OP_TICK,   32'h0000_0000, 3'd1);  // disabled tick: no switch
        send_op(OP_RSVD_6, 32'hFFFF_FFFF, 3'd7);
        send_op(OP_RSVD_7, 32'h0000_0000, 3'd0);
        send_op(OP_YIELD,  32'h1234_5678, 3'd2);  // yield while idle
        send_op(OP_DELAY,  32'hFFFF_FFFF, 3'd3);  // delay while idle
        send_op(OP_EXIT,   32'h0000_0000, 3'd4);  // exit while idle
        send_op(OP_DELETE, 32'h0000_0000, 3'd0);  // idle slot cannot be freed
        send_op(OP_DELETE, 32'hA5A5_A5A5, 3'd7);  // free slot that is not in use
        repeat (7) send_op(OP_ADD, 32'h0, 3'd1);  // fill the table
        send_op(OP_ADD,    32'h0000_0000, 3'd1);  // table full
        write_sched_enable(1'b1);
        send_op(OP_TICK,   32'h0000_0000, 3'd1);  // slot 1 becomes ready
        send_op(OP_DELAY,  32'h0000_0005, 3'd1);
        send_op(OP_TICK,   32'h0000_0000, 3'd1);
        send_op(OP_YIELD,  32'h0000_0000, 3'd1);
        send_op(OP_TICK,   32'h0000_0000, 3'd1);
        send_op(OP_EXIT,   32'h0000_0000, 3'd1);  // exit a real task
        send_op(OP_DELETE, 32'h0000_0000, 3'd4);
        send_op(OP_DELAY,  32'hFFFF_FFFF, 3'd1);  // stamp+wait wraps
        send_op(OP_DELETE, 32'h0000_0000, 3'd0);
        send_op(OP_ADD,    32'h0000_0000, 3'd1);  // reuse a freed slot
    endtask

    task automatic test_random_streaming();
        write_sched_enable(1'b1);
        set_idling(0, 0);
        repeat (260) send_random_op();
    endtask

    task automatic test_sender_gaps();
        write_sched_enable(1'b1);
        set_idling(59, 0);
        repeat (260) send_random_op();
    endtask

    task automatic test_scheduler_disabled();
        write_sched_enable(1'b0);
        set_idling(14, 14);
        repeat (80) send_random_op();
    endtask

    task automatic test_receiver_stalls();
        write_sched_enable(1'b1);
        set_idling(0, 59);
        repeat (260) send_random_op();
    endtask

    task automatic test_both_sides_idle();
        write_sched_enable(1'b1);
        set_idling(14, 14);
        repeat (260) send_random_op();
    endtask

    // output held off while input keeps offering, then a full drain pause
    task automatic test_output_hold_off();
        set_idling(0, 0);
        hold_request = 1'b1;
        repeat (30) send_random_op();
        drain_results();
        repeat (20) send_random_op();
    endtask

    initial begin
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_streaming();
        test_sender_gaps();
        test_scheduler_disabled();
        test_receiver_stalls();
        test_both_sides_idle();
        test_output_hold_off();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("ERROR: %0d expected results never arrived", pending_results.size());
            bad_beats += pending_results.size();
        end
        if (bad_beats == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
